@@ src/crfe_pkg.sv @@
// ----------------------------------------------------------------------------
// crfe_pkg
// Shared types and constants for the clipped rectangle fill engine: beat
// function codes, configuration register indexes, pixel formats and the
// RGB565 color conversion.
// ----------------------------------------------------------------------------
package crfe_pkg;

    // Function carried in the input beat's tuser.
    typedef enum logic {
        FUNC_START   = 1'b0,
        FUNC_ADVANCE = 1'b1
    } func_t;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_FB_BASE       = 3'd0,
        CFG_STRIDE_PIXELS = 3'd1,
        CFG_VISIBLE_ROWS  = 3'd2,
        CFG_LINE_BYTES    = 3'd3,
        CFG_PIXEL_FORMAT  = 3'd4
    } cfg_index_t;

    // Pixel formats.
    typedef enum logic {
        FMT_ARGB8888 = 1'b0,
        FMT_RGB565   = 1'b1
    } pixel_format_t;

    // Fixed register widths.
    localparam int FB_BASE_BITS = 32;
    localparam int STRIDE_BITS  = 13;
    localparam int ROWS_BITS    = 13;
    localparam int LINE_BITS    = 16;
    localparam int COLOR_BITS   = 32;

    // Register reset values.
    localparam logic [FB_BASE_BITS-1:0] FB_BASE_RST      = 32'd0;
    localparam logic [STRIDE_BITS-1:0]  STRIDE_RST       = 13'd640;
    localparam logic [ROWS_BITS-1:0]    VISIBLE_ROWS_RST = 13'd480;
    localparam logic [LINE_BITS-1:0]    LINE_BYTES_RST   = 16'd2560;

    // Convert an ARGB8888 color to RGB565 in the low half word; alpha is dropped.
    function automatic logic [COLOR_BITS-1:0] to_rgb565(input logic [COLOR_BITS-1:0] c);
        to_rgb565 = {16'h0000, c[23:19], c[15:10], c[7:3]};
    endfunction

endpackage

@@ src/clipped_rect_fill_engine.sv @@
// ----------------------------------------------------------------------------
// clipped_rect_fill_engine
// Solid rectangle fill for a double-buffered framebuffer. A start beat clips
// the rectangle to the row width and the visible rows and latches the buffer
// base and pixel word; each advance beat during a fill emits one pixel write in raster order.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake          | Contents
//  ---------+-----------+--------------------+-----------------------------------
//  s_       | in        | s_tvalid/s_tready  | tuser: func; tdata: rectangle, color
//  m_       | out       | m_tvalid/m_tready  | tdata: address, pixel; tlast
//  cfg_     | in        | cfg_we             | cfg_index, cfg_wdata
//
//  One beat per cycle is sustained while the skid entry is empty; an advance
//  beat passes through the input register, then the result register, before
//  its pixel is offered on m_.
//  The address path is one 14x13 multiply, the column add and a three-input add.
//  A two-entry result buffer lets the input keep flowing while m_tready is low
//  until the skid entry fills; then s_tready drops, once a beat waits in the
//  input register, until the skid entry moves on to the output register.
//  aresetn is synchronous and active low; it restores the register defaults
//  and ends any fill in progress.
//
module clipped_rect_fill_engine #(
    parameter int COORD_BITS = 14,
    parameter int ADDR_BITS  = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Input beats.
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // tdata from bit 0: buffer_id, rect_x, rect_y, rect_w, rect_h, fill_color
    input  logic [((1+4*COORD_BITS+32+7)/8)*8-1:0] s_tdata,
    // tuser: func
    input  logic                                  s_tuser,
    // Result beats.
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // tdata from bit 0: byte_address, pixel_data
    output logic [((ADDR_BITS+32+7)/8)*8-1:0]     m_tdata,
    output logic                                  m_tlast,
    // Configuration writes.
    input  logic                                  cfg_we,
    input  logic [crfe_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [crfe_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);
    import crfe_pkg::*;

    localparam int CW    = COORD_BITS;
    localparam int EW    = ((COORD_BITS > STRIDE_BITS) ? COORD_BITS : STRIDE_BITS) + 2;
    localparam int LW    = CW + STRIDE_BITS + 1;
    localparam int OW    = LW + 2;
    localparam int OUT_W = ((ADDR_BITS + 32 + 7) / 8) * 8;

    // Field offsets inside s_tdata.
    localparam int X_LSB = 1;
    localparam int Y_LSB = X_LSB + CW;
    localparam int W_LSB = Y_LSB + CW;
    localparam int H_LSB = W_LSB + CW;
    localparam int C_LSB = H_LSB + CW;

    // Configuration registers.
    logic [FB_BASE_BITS-1:0] fb_base_reg;
    logic [STRIDE_BITS-1:0]  stride_reg;
    logic [ROWS_BITS-1:0]    visible_rows_reg;
    logic [LINE_BITS-1:0]    line_bytes_reg;
    pixel_format_t           pixel_format_reg;

    // Input register.
    logic                    in_valid_reg;
    func_t                   in_func_reg;
    logic                    in_buf_reg;
    logic [CW-1:0]           in_x_reg;
    logic [CW-1:0]           in_y_reg;
    logic [CW-1:0]           in_w_reg;
    logic [CW-1:0]           in_h_reg;
    logic [COLOR_BITS-1:0]   in_color_reg;

    // Fill state.
    logic                    busy_reg, busy_next;
    logic [CW-1:0]           cur_col_reg, cur_col_next;
    logic [CW-1:0]           cur_row_reg, cur_row_next;
    logic [CW-1:0]           first_col_reg, first_col_next;
    logic [CW-1:0]           limit_col_reg, limit_col_next;
    logic [CW-1:0]           limit_row_reg, limit_row_next;
    logic [COLOR_BITS-1:0]   pixel_word_reg, pixel_word_next;
    logic [31:0]             buffer_base_reg, buffer_base_next;

    // Result buffer: output register plus skid entry.
    logic                    out_valid_reg;
    logic [ADDR_BITS-1:0]    out_addr_reg;
    logic [COLOR_BITS-1:0]   out_pixel_reg;
    logic                    out_last_reg;
    logic                    skid_valid_reg;
    logic [ADDR_BITS-1:0]    skid_addr_reg;
    logic [COLOR_BITS-1:0]   skid_pixel_reg;
    logic                    skid_last_reg;

    // Work signals.
    logic                    s_fire;
    logic                    m_fire;
    logic                    proc;
    logic                    res_valid;
    logic                    res_last;
    logic [ADDR_BITS-1:0]    res_addr;
    logic signed [EW-1:0]    x_e, y_e, w_e, h_e, ex, ey, sx, sy, ex_c, ey_c;
    logic signed [EW-1:0]    stride_e, rows_e;
    logic [ROWS_BITS+LINE_BITS-1:0] bb_prod;
    logic [CW+STRIDE_BITS-1:0] row_prod;
    logic [LW-1:0]           lin;
    logic [OW-1:0]           offset;
    logic [CW-1:0]           ncol, nrow;

    assign s_tready = !in_valid_reg || !skid_valid_reg;
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = out_valid_reg && m_tready;
    assign proc     = in_valid_reg && !skid_valid_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = OUT_W'({out_pixel_reg, out_addr_reg});

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fb_base_reg      <= FB_BASE_RST;
            stride_reg       <= STRIDE_RST;
            visible_rows_reg <= VISIBLE_ROWS_RST;
            line_bytes_reg   <= LINE_BYTES_RST;
            pixel_format_reg <= FMT_ARGB8888;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_FB_BASE:       fb_base_reg      <= cfg_wdata[FB_BASE_BITS-1:0];
                CFG_STRIDE_PIXELS: stride_reg       <= cfg_wdata[STRIDE_BITS-1:0];
                CFG_VISIBLE_ROWS:  visible_rows_reg <= cfg_wdata[ROWS_BITS-1:0];
                CFG_LINE_BYTES:    line_bytes_reg   <= cfg_wdata[LINE_BITS-1:0];
                CFG_PIXEL_FORMAT:  pixel_format_reg <= pixel_format_t'(cfg_wdata[0]);
                default: begin
                end
            endcase
        end
    end

    // Input register: loads on an accepted beat, empties once processed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (proc) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_func_reg  <= func_t'(s_tuser);
            in_buf_reg   <= s_tdata[0];
            in_x_reg     <= s_tdata[X_LSB +: CW];
            in_y_reg     <= s_tdata[Y_LSB +: CW];
            in_w_reg     <= s_tdata[W_LSB +: CW];
            in_h_reg     <= s_tdata[H_LSB +: CW];
            in_color_reg <= s_tdata[C_LSB +: COLOR_BITS];
        end
    end

    // Start path: clip the rectangle in a signed width wide enough for all cases.
    always_comb begin
        x_e      = {{(EW-CW){in_x_reg[CW-1]}}, in_x_reg};
        y_e      = {{(EW-CW){in_y_reg[CW-1]}}, in_y_reg};
        w_e      = {{(EW-CW){1'b0}}, in_w_reg};
        h_e      = {{(EW-CW){1'b0}}, in_h_reg};
        stride_e = {{(EW-STRIDE_BITS){1'b0}}, stride_reg};
        rows_e   = {{(EW-ROWS_BITS){1'b0}}, visible_rows_reg};
        sx       = (x_e > 0) ? x_e : '0;
        sy       = (y_e > 0) ? y_e : '0;
        ex       = x_e + w_e;
        ey       = y_e + h_e;
        ex_c     = (ex > stride_e) ? stride_e : ex;
        ey_c     = (ey > rows_e) ? rows_e : ey;
        bb_prod  = (ROWS_BITS+LINE_BITS)'(visible_rows_reg)
                 * (ROWS_BITS+LINE_BITS)'(line_bytes_reg);
    end

    // Advance path: pixel address from the current position.
    always_comb begin
        row_prod = (CW+STRIDE_BITS)'(cur_row_reg) * (CW+STRIDE_BITS)'(stride_reg);
        lin      = {1'b0, row_prod} + {{(LW-CW){1'b0}}, cur_col_reg};
        offset   = (pixel_format_reg == FMT_RGB565) ? {1'b0, lin, 1'b0} : {lin, 2'b00};
        res_addr = ADDR_BITS'(fb_base_reg) + ADDR_BITS'(buffer_base_reg)
                 + ADDR_BITS'(offset);
        ncol     = cur_col_reg + CW'(1);
        nrow     = cur_row_reg + CW'(1);
    end

    // Next fill state and the result of the processed beat.
    always_comb begin
        busy_next        = busy_reg;
        cur_col_next     = cur_col_reg;
        cur_row_next     = cur_row_reg;
        first_col_next   = first_col_reg;
        limit_col_next   = limit_col_reg;
        limit_row_next   = limit_row_reg;
        pixel_word_next  = pixel_word_reg;
        buffer_base_next = buffer_base_reg;
        res_valid        = 1'b0;
        res_last         = 1'b0;
        if (proc) begin
            if (in_func_reg == FUNC_START) begin
                pixel_word_next  = (pixel_format_reg == FMT_RGB565) ?
                                   to_rgb565(in_color_reg) : in_color_reg;
                buffer_base_next = in_buf_reg ? 32'(bb_prod) : '0;
                busy_next        = (ex_c > sx) && (ey_c > sy);
                first_col_next   = sx[CW-1:0];
                cur_col_next     = sx[CW-1:0];
                cur_row_next     = sy[CW-1:0];
                limit_col_next   = ex_c[CW-1:0];
                limit_row_next   = ey_c[CW-1:0];
            end else if (busy_reg) begin
                res_valid = 1'b1;
                if (ncol == limit_col_reg) begin
                    cur_col_next = first_col_reg;
                    cur_row_next = nrow;
                    if (nrow == limit_row_reg) begin
                        res_last  = 1'b1;
                        busy_next = 1'b0;
                    end
                end else begin
                    cur_col_next = ncol;
                end
            end
        end
    end

    // Fill state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_col_reg     <= cur_col_next;
        cur_row_reg     <= cur_row_next;
        first_col_reg   <= first_col_next;
        limit_col_reg   <= limit_col_next;
        limit_row_reg   <= limit_row_next;
        pixel_word_reg  <= pixel_word_next;
        buffer_base_reg <= buffer_base_next;
    end

    // Result buffer control: the skid entry only fills while the output stalls.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_fire) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (res_valid) begin
            if (out_valid_reg && !m_fire) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (m_fire) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result buffer data.
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_fire) begin
                out_addr_reg  <= skid_addr_reg;
                out_pixel_reg <= skid_pixel_reg;
                out_last_reg  <= skid_last_reg;
            end
        end else if (res_valid) begin
            if (out_valid_reg && !m_fire) begin
                skid_addr_reg  <= res_addr;
                skid_pixel_reg <= pixel_word_reg;
                skid_last_reg  <= res_last;
            end else begin
                out_addr_reg  <= res_addr;
                out_pixel_reg <= pixel_word_reg;
                out_last_reg  <= res_last;
            end
        end
    end

    // The skid entry is never occupied while the output register is empty.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a pixel while the output register is empty");

    // Input stalls only with a held beat and a full result buffer.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && skid_valid_reg && out_valid_reg))
        else $error("input stalled without a full result buffer");

    // The final pixel of a fill ends the fill.
    a_last_ends_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_last) |=> !busy_reg)
        else $error("fill still running after its final pixel");

    // A pixel is produced only while a fill is running.
    a_pixel_needs_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (busy_reg && in_func_reg == FUNC_ADVANCE))
        else $error("pixel produced without a running fill");

endmodule

@@ bench/crfe_fill_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crfe_fill_checker
// Watches the input, result and configuration ports of the rectangle fill
// engine. It keeps its own copy of the registers and of the fill in progress,
// and predicts the pixel write that each accepted advance beat should cause.
// Each accepted result beat is compared field by field with the oldest
// prediction. The count of pending predictions and of failures goes to the top.
// ----------------------------------------------------------------------------
module crfe_fill_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // tdata from bit 0: buffer_id, rect_x, rect_y, rect_w, rect_h, fill_color
    input  logic [95:0] s_tdata,
    // tuser: func
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // tdata from bit 0: byte_address, pixel_data
    input  logic [63:0] m_tdata,
    input  logic        m_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    output int          n_pending,
    output int          n_fail
);
    import crfe_pkg::*;

    typedef struct packed {
        logic [31:0] byte_address;
        logic [31:0] pixel_data;
        logic        last;
    } pixel_write_t;

    pixel_write_t pixel_writes_due[$];
    int           fail_count;

    // Register copies.
    logic [31:0]   fb_base;
    logic [12:0]   stride;
    logic [12:0]   rows;
    logic [15:0]   line_bytes;
    pixel_format_t fmt;

    // Fill in progress.
    logic        filling;
    logic [13:0] col;
    logic [13:0] row;
    logic [13:0] col_first;
    logic [13:0] col_end;
    logic [13:0] row_end;
    logic [31:0] fill_word;
    logic [31:0] fill_base;

    // A start beat clips the rectangle and latches base and pixel word.
    task automatic latch_fill(input logic [95:0] d);
        logic signed [13:0] xs;
        logic signed [13:0] ys;
        logic [31:0]        color;
        int                 x0;
        int                 y0;
        int                 x1;
        int                 y1;
        xs    = d[14:1];
        ys    = d[28:15];
        color = d[88:57];
        x0 = (xs > 0) ? int'(xs) : 0;
        y0 = (ys > 0) ? int'(ys) : 0;
        x1 = int'(xs) + int'(d[42:29]);
        y1 = int'(ys) + int'(d[56:43]);
        if (x1 > int'(stride)) x1 = int'(stride);
        if (y1 > int'(rows)) y1 = int'(rows);
        if (fmt == FMT_RGB565) begin
            fill_word = ((32'(color[23:16]) & 32'hf8) << 8)
                      | ((32'(color[15:8]) & 32'hfc) << 3)
                      | ((32'(color[7:0]) & 32'hf8) >> 3);
        end else begin
            fill_word = color;
        end
        fill_base = d[0] ? ({19'd0, rows} * {16'd0, line_bytes}) : 32'd0;
        if (x1 > x0 && y1 > y0) begin
            filling   = 1'b1;
            col_first = 14'(x0);
            col       = 14'(x0);
            row       = 14'(y0);
            col_end   = 14'(x1);
            row_end   = 14'(y1);
        end else begin
            filling = 1'b0;
        end
    endtask

    // An advance beat yields one pixel write while a fill is in progress.
    task automatic step_fill();
        pixel_write_t pw;
        logic [63:0]  offset;
        logic [13:0]  next_col;
        logic [13:0]  next_row;
        if (filling) begin
            offset = (64'(row) * 64'(stride) + 64'(col))
                   * 64'((fmt == FMT_RGB565) ? 2 : 4);
            pw.byte_address = fb_base + fill_base + offset[31:0];
            pw.pixel_data   = fill_word;
            pw.last         = 1'b0;
            next_col = col + 14'd1;
            if (next_col == col_end) begin
                next_row = row + 14'd1;
                if (next_row == row_end) begin
                    pw.last = 1'b1;
                    filling = 1'b0;
                end
                col = col_first;
                row = next_row;
            end else begin
                col = next_col;
            end
            pixel_writes_due.push_back(pw);
        end
    endtask

    // Compare one result beat with the oldest prediction.
    task automatic check_pixel_write();
        pixel_write_t want;
        if (pixel_writes_due.size() == 0) begin
            $display("%0t: unexpected pixel write addr %h data %h last %b",
                     $time, m_tdata[31:0], m_tdata[63:32], m_tlast);
            fail_count++;
        end else begin
            want = pixel_writes_due.pop_front();
            if (m_tdata[31:0] !== want.byte_address) begin
                $display("%0t: byte_address expected %h got %h",
                         $time, want.byte_address, m_tdata[31:0]);
                fail_count++;
            end
            if (m_tdata[63:32] !== want.pixel_data) begin
                $display("%0t: pixel_data expected %h got %h",
                         $time, want.pixel_data, m_tdata[63:32]);
                fail_count++;
            end
            if (m_tlast !== want.last) begin
                $display("%0t: last expected %b got %b", $time, want.last, m_tlast);
                fail_count++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            fb_base    = FB_BASE_RST;
            stride     = STRIDE_RST;
            rows       = VISIBLE_ROWS_RST;
            line_bytes = LINE_BYTES_RST;
            fmt        = FMT_ARGB8888;
            filling    = 1'b0;
            col        = '0;
            row        = '0;
            col_first  = '0;
            col_end    = '0;
            row_end    = '0;
            fill_word  = '0;
            fill_base  = '0;
            fail_count = 0;
            pixel_writes_due.delete();
        end else begin
            // Results first: a beat accepted now cannot answer an input of this edge.
            if (m_tvalid && m_tready) check_pixel_write();
            if (cfg_we) begin
                case (cfg_index_t'(cfg_index))
                    CFG_FB_BASE:       fb_base    = cfg_wdata;
                    CFG_STRIDE_PIXELS: stride     = cfg_wdata[12:0];
                    CFG_VISIBLE_ROWS:  rows       = cfg_wdata[12:0];
                    CFG_LINE_BYTES:    line_bytes = cfg_wdata[15:0];
                    CFG_PIXEL_FORMAT:  fmt        = pixel_format_t'(cfg_wdata[0]);
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (func_t'(s_tuser) == FUNC_START) begin
                    latch_fill(s_tdata);
                end else begin
                    step_fill();
                end
            end
        end
        n_pending <= pixel_writes_due.size();
        n_fail    <= fail_count;
    end

endmodule

@@ bench/tb_clipped_rect_fill_engine.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_clipped_rect_fill_engine
// Drives the fill engine with a directed set of rectangles (clipped on every
// side, empty, abandoned, at the coordinate and register extremes) and then
// with phases of random fills under different register settings and with
// random idling on both channels. A checker beside the block predicts and
// compares every pixel write; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_clipped_rect_fill_engine;
    import crfe_pkg::*;

    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_BEATS    = 60;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;

    int n_pending;
    int n_fail;

    // Idling percentages of the current phase and the hold-off request toggle.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_flip      = 1'b0;

    // Register settings as last written, so fills can aim at the visible area.
    int cur_stride = 640;
    int cur_rows   = 480;
    int beats_sent = 0;

    clipped_rect_fill_engine u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    crfe_fill_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .n_pending (n_pending),
        .n_fail    (n_fail)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Offer one beat after a random gap and hold it until it is taken.
    task automatic send_beat(input func_t f, input logic id, input logic [13:0] x,
                             input logic [13:0] y, input logic [13:0] w,
                             input logic [13:0] h, input logic [31:0] color);
        while (int'($urandom_range(99)) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {7'd0, color, h, w, y, x, id};
        do @(posedge aclk); while (!s_tready);
        beats_sent++;
    endtask

    task automatic send_advance();
        send_beat(FUNC_ADVANCE, 1'($urandom), 14'($urandom), 14'($urandom),
                  14'($urandom), 14'($urandom), $urandom);
    endtask

    // Start a fill and send as many advances as its clipped area, plus extra.
    task automatic send_fill(input logic id, input int x, input int y, input int w,
                             input int h, input logic [31:0] color, input int extra);
        int cw;
        int ch;
        int n;
        cw = ((x + w < cur_stride) ? x + w : cur_stride) - ((x > 0) ? x : 0);
        ch = ((y + h < cur_rows) ? y + h : cur_rows) - ((y > 0) ? y : 0);
        n  = ((cw > 0 && ch > 0) ? cw * ch : 0) + extra;
        send_beat(FUNC_START, id, 14'(x), 14'(y), 14'(w), 14'(h), color);
        repeat ((n > 0) ? n : 0) send_advance();
    endtask

    // Stop offering and wait until every pixel write is in, then let the pipe settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    // Write all registers; only called with the block idle.
    task automatic set_registers(input logic [31:0] fb, input int stride, input int rows,
                                 input int line, input pixel_format_t fmt);
        write_reg(CFG_FB_BASE, fb);
        write_reg(CFG_STRIDE_PIXELS, 32'(stride));
        write_reg(CFG_VISIBLE_ROWS, 32'(rows));
        write_reg(CFG_LINE_BYTES, 32'(line));
        write_reg(CFG_PIXEL_FORMAT, 32'(fmt));
        cfg_we     <= 1'b0;
        cur_stride = stride;
        cur_rows   = rows;
    endtask

    // A coordinate near the low edge, near the high edge, or anywhere inside.
    function automatic int pick_coord(input int limit);
        case ($urandom_range(2))
            0:       return int'($urandom_range(5)) - 3;
            1:       return limit - 4 + int'($urandom_range(5));
            default: return int'($urandom_range(limit + 2)) - 3;
        endcase
    endfunction

    // Result side: random stalls, and one long hold-off when asked for.
    initial begin
        bit seen_flip;
        seen_flip = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_flip != seen_flip) begin
                seen_flip = hold_flip;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= (int'($urandom_range(99)) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: too long without any beat on either channel ends the run.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int  ph;
        int  target;
        int  r;
        int  w;
        int  h;
        int  extra;
        bit  held;
        bit  paused;
        held   = 1'b0;
        paused = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, default registers first.
        send_advance();                                        // advance with no fill
        send_fill(1'b0, -2, -1, 4, 3, 32'h12345678, 1);        // clipped left and top
        send_fill(1'b1, 638, 478, 16383, 16383, 32'hffffffff, -2); // abandoned
        send_fill(1'b0, -8192, -8192, 0, 0, 32'h00000000, 1);  // empty, replaces a fill
        send_fill(1'b1, 8191, 8191, 16383, 16383, 32'h0, 1);   // entirely off screen
        send_fill(1'b0, -8192, 0, 8193, 1, 32'h80ff00ff, 0);   // single pixel
        wait_idle();
        // Largest registers, 16-bit pixels, address wrap.
        set_registers(32'hffffffff, 8191, 8191, 65535, FMT_RGB565);
        send_fill(1'b1, 8190, 8190, 5, 5, 32'hfff8fcf8, 0);
        send_fill(1'b0, 8189, -5, 3, 7, 32'h00070307, 0);
        wait_idle();

        // Random phases: minimum, maximum and random registers, both formats.
        for (ph = 0; ph < 8; ph++) begin
            case (ph % 3)
                0: set_registers(32'h0, 1, 1, 1, pixel_format_t'(ph % 2));
                1: set_registers(32'hffffffff, 8191, 8191, 65535, pixel_format_t'(ph % 2));
                default: set_registers($urandom, $urandom_range(1, 64), $urandom_range(1, 64),
                                       $urandom_range(1, 65535), pixel_format_t'(ph % 2));
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            target = beats_sent + PHASE_BEATS;
            while (beats_sent < target) begin
                // Long receiver hold-off while a large fill keeps the input busy.
                if (ph == 4 && !held && beats_sent > target - 50) begin
                    held = 1'b1;
                    hold_flip <= ~hold_flip;
                    send_fill(1'($urandom), 10, 10, 6, 6, $urandom, 0);
                end
                // Sender pause until every pixel write has arrived.
                if (ph == 5 && !paused && beats_sent > target - 35) begin
                    paused = 1'b1;
                    wait_idle();
                end
                r = $urandom_range(99);
                if (r < 80) begin
                    w = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
                    h = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 5);
                    case ($urandom_range(9))
                        0:       extra = -2;
                        1:       extra = 1;
                        default: extra = 0;
                    endcase
                    send_fill(1'($urandom), pick_coord(cur_stride), pick_coord(cur_rows),
                              w, h, $urandom, extra);
                end else if (r < 92) begin
                    send_beat(FUNC_START, 1'($urandom), 14'($urandom), 14'($urandom),
                              14'($urandom), 14'($urandom), $urandom);
                    repeat ($urandom_range(6)) send_advance();
                end else begin
                    send_advance();
                end
            end
            wait_idle();
        end

        if (n_fail == 0 && n_pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
